// File: rtl/core/ptfd_pkg.sv
// ptfd_pkg: shared types and constants for the psk tag frame decoder
// no dependencies
`default_nettype none
package ptfd_pkg;
    localparam int FRAME_BITS = 96;
    localparam logic [9:0] PERIOD_RST = 10'd255;
    localparam logic [9:0] ADJUST_RST = 10'd120;
    localparam logic [7:0] PREAMBLE_RST = 8'h56;

    localparam logic [1:0] REG_PERIOD = 2'd0;
    localparam logic [1:0] REG_ADJUST = 2'd1;
    localparam logic [1:0] REG_PREAMBLE = 2'd2;

    typedef struct packed {
        logic        pulse_level;
        logic [19:0] pulse_duration;
    } in_item_t;

    typedef struct packed {
        logic        frame_found;
        logic [31:0] card_word;
        logic [23:0] trailer_bits;
    } out_item_t;

    // controller to datapath commands
    typedef struct packed {
        logic       load;      // capture input item
        logic       div_start; // start bit count division for hypothesis sel
        logic [1:0] sel;       // register under trial
        logic       push;      // shift one bit into sel register
        logic       cnt_load;  // load bit count from quotient
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic div_busy;
        logic count_ok;   // period nonzero and quotient below frame size
        logic more;       // bits left to push
        logic match;      // frame check passes on sel register
        logic try_ab;
        logic try_cd;
    } stat_t;

    function automatic logic [3:0] swap_ends(input logic [3:0] p);
        swap_ends = {p[0], p[2:1], p[3]};
    endfunction

    // frame test, bit 0 (oldest) in f[95]
    function automatic logic frame_ok(input logic [95:0] f, input logic [7:0] pre);
        logic [3:0] p;
        p = 4'd0;
        for (int i = 0; i < 9; i++)
            p = p ^ f[55-4*i -: 4];
        frame_ok = (f[95:88] == pre) && (f[87:56] == 32'd0) && (swap_ends(p) == f[19:16]);
    endfunction
endpackage
`default_nettype wire

// File: rtl/core/ptfd_div.sv
// ptfd_div: restoring divider, one quotient bit per cycle
// depends on nothing
`default_nettype none
module ptfd_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [20:0] dividend,
    input  wire logic [9:0]  divisor,
    output logic             busy,
    output logic [20:0]      quotient
);
    logic [20:0] q_reg;
    logic [10:0] r_reg;
    logic [4:0]  n_reg;
    logic [11:0] trial;
    logic [10:0] rs;

    assign rs = {r_reg[9:0], q_reg[20]};
    assign trial = {1'b0, rs} - {2'b0, divisor};
    assign busy = (n_reg != 5'd0);
    assign quotient = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg <= '0;
            q_reg <= '0;
            r_reg <= '0;
        end
        else if (start)
        begin
            n_reg <= 5'd21;
            q_reg <= dividend;
            r_reg <= '0;
        end
        else if (busy)
        begin
            n_reg <= n_reg - 5'd1;
            if (!trial[11])
            begin
                r_reg <= trial[10:0];
                q_reg <= {q_reg[19:0], 1'b1};
            end
            else
            begin
                r_reg <= rs;
                q_reg <= {q_reg[19:0], 1'b0};
            end
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/ptfd_datapath.sv
// ptfd_datapath: shift registers, bit counter, frame check, result latch
// depends on ptfd_pkg, ptfd_div
`default_nettype none
module ptfd_datapath (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire ptfd_pkg::in_item_t in_item,
    input  wire ptfd_pkg::cmd_t   cmd,
    input  wire logic             set_found,
    input  wire logic [9:0]       period,
    input  wire logic [9:0]       adjust,
    input  wire logic [7:0]       preamble,
    output ptfd_pkg::stat_t       stat,
    output logic [55:0]           decoded
);
    import ptfd_pkg::*;

    logic [95:0] sr_reg [4];
    logic        lvl_reg;
    logic [19:0] dur_reg;
    logic [20:0] adur;
    logic [20:0] dur_sel;
    logic [20:0] quot;
    logic [6:0]  cnt_reg;
    logic [55:0] dec_reg;
    logic [95:0] nxt;
    logic        bit_in;

    assign adur = lvl_reg ? ({1'b0, dur_reg} + 21'(adjust))
                : (dur_reg > 20'(adjust)) ? ({1'b0, dur_reg} - 21'(adjust)) : {1'b0, dur_reg};
    assign dur_sel = (cmd.sel[1] ? adur : {1'b0, dur_reg}) + 21'(period[9:1]);

    ptfd_div u_div (
        .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
        .dividend(dur_sel), .divisor(period),
        .busy(stat.div_busy), .quotient(quot)
    );

    assign bit_in = lvl_reg ^ cmd.sel[0];
    assign nxt = {sr_reg[cmd.sel][94:0], bit_in};
    assign stat.count_ok = (period != 10'd0) && (quot < 21'(FRAME_BITS));
    assign stat.more = (cnt_reg != 7'd0);
    assign stat.match = frame_ok(sr_reg[cmd.sel], preamble);
    assign stat.try_ab = dur_reg > 20'(period[9:1]);
    assign stat.try_cd = dur_reg > 20'(period[9:2]);
    assign decoded = dec_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
                sr_reg[i] <= '0;
            dec_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (cmd.push)
            begin
                sr_reg[cmd.sel] <= nxt;
                cnt_reg <= cnt_reg - 7'd1;
            end
            else if (cmd.cnt_load)
                cnt_reg <= stat.count_ok ? quot[6:0] : 7'd0;
            if (set_found)
                dec_reg <= sr_reg[cmd.sel][55:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            lvl_reg <= in_item.pulse_level;
            dur_reg <= in_item.pulse_duration;
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/ptfd_ctrl.sv
// ptfd_ctrl: sequencer over the four hypotheses and the push/check loop
// depends on ptfd_pkg
`default_nettype none
module ptfd_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  wire logic           out_ready,
    input  wire ptfd_pkg::stat_t stat,
    output ptfd_pkg::cmd_t      cmd,
    output logic                set_found,
    output logic                found
);
    import ptfd_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_NEXT, S_DIV, S_CNT, S_PUSH, S_CHECK, S_OUT} state_t;
    state_t     st_reg;
    logic [1:0] sel_reg;
    logic       found_reg;
    logic       started_reg;

    assign in_ready = (st_reg == S_IDLE);
    assign out_valid = (st_reg == S_OUT);
    assign found = found_reg;
    assign cmd.load = in_valid && in_ready;
    assign cmd.sel = sel_reg;
    assign cmd.push = (st_reg == S_PUSH);
    assign cmd.cnt_load = (st_reg == S_CNT);
    assign cmd.div_start = (st_reg == S_NEXT) && started_reg;
    assign set_found = (st_reg == S_CHECK) && stat.match && found_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            sel_reg <= '0;
            found_reg <= 1'b0;
            started_reg <= 1'b0;
        end
        else
        begin
            unique case (st_reg)
                S_IDLE:
                    if (in_valid)
                    begin
                        st_reg <= S_NEXT;
                        sel_reg <= 2'd0;
                        found_reg <= 1'b0;
                        started_reg <= 1'b0;
                    end
                S_NEXT:
                begin
                    // on the first visit pick the first hypothesis allowed; on later visits start the division
                    if (!started_reg)
                    begin
                        started_reg <= 1'b1;
                        if (!stat.try_ab)
                        begin
                            sel_reg <= 2'd2;
                            if (!stat.try_cd)
                                st_reg <= S_OUT;
                        end
                    end
                    else
                        st_reg <= S_DIV;
                end
                S_DIV:
                    if (!stat.div_busy)
                        st_reg <= S_CNT;
                S_CNT:
                    st_reg <= S_CHECK;
                S_PUSH:
                    st_reg <= S_CHECK;
                S_CHECK:
                    if (stat.match && found_reg)
                        st_reg <= S_OUT;
                    else if (stat.more)
                        st_reg <= S_PUSH;
                    else if (sel_reg == 2'd3 || (sel_reg == 2'd1 && !stat.try_cd))
                        st_reg <= S_OUT;
                    else
                    begin
                        sel_reg <= sel_reg + 2'd1;
                        st_reg <= S_NEXT;
                    end
                S_OUT:
                    if (out_ready)
                        st_reg <= S_IDLE;
                default:
                    st_reg <= S_IDLE;
            endcase
            // matches count only right after a push
            if (st_reg == S_PUSH)
                found_reg <= 1'b1;
            else if (st_reg == S_CNT)
                found_reg <= 1'b0;
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/psk_tag_frame_decoder_core.sv
// psk_tag_frame_decoder_core: top level, config registers and block wiring
// depends on ptfd_pkg, ptfd_ctrl, ptfd_datapath, ptfd_div
//
// channel   direction  handshake           payload
// in        input      in_valid/in_ready   ptfd_pkg::in_item_t
// out       output     out_valid/out_ready ptfd_pkg::out_item_t
// apb       input      psel/penable/pready register write/read
//
// one item at a time; the controller first picks the first hypothesis, then each
// hypothesis starts the 21-step serial divider, waits for it, loads the count and
// checks once, then pushes and checks again for each bit to shift in
// reset clears shift registers, result latch and registers to defaults
// a waiting result holds the block until taken
`default_nettype none
module psk_tag_frame_decoder_core (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire ptfd_pkg::in_item_t  in_item,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output ptfd_pkg::out_item_t      out_item,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [3:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);
    import ptfd_pkg::*;

    logic [9:0]  period_reg;
    logic [9:0]  adjust_reg;
    logic [7:0]  preamble_reg;
    cmd_t        cmd;
    stat_t       stat;
    logic        set_found;
    logic        found;
    logic [55:0] decoded;
    logic        hit_reg;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RST;
            adjust_reg <= ADJUST_RST;
            preamble_reg <= PREAMBLE_RST;
        end
        else if (psel && penable && pwrite && paddr[1:0] == 2'b00)
        begin
            unique case (paddr[3:2])
                REG_PERIOD: period_reg <= pwdata[9:0];
                REG_ADJUST: adjust_reg <= pwdata[9:0];
                REG_PREAMBLE: preamble_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_PERIOD: prdata = {22'd0, period_reg};
            REG_ADJUST: prdata = {22'd0, adjust_reg};
            REG_PREAMBLE: prdata = {24'd0, preamble_reg};
            default: prdata = 32'd0;
        endcase
    end

    ptfd_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready), .stat(stat), .cmd(cmd),
        .set_found(set_found), .found(found)
    );

    ptfd_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .in_item(in_item), .cmd(cmd), .set_found(set_found),
        .period(period_reg), .adjust(adjust_reg), .preamble(preamble_reg),
        .stat(stat), .decoded(decoded)
    );

    // found flag: a match seen after a push of this item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hit_reg <= 1'b0;
        else if (cmd.load)
            hit_reg <= 1'b0;
        else if (set_found && found)
            hit_reg <= 1'b1;
    end

    assign out_item.frame_found = hit_reg;
    assign out_item.card_word = decoded[55:24];
    assign out_item.trailer_bits = decoded[23:0];

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("accept while result pending");
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready) else $error("ready after accept");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
endmodule
`default_nettype wire

// File: test/psk_tag_frame_decoder_core_tb.sv
// psk_tag_frame_decoder_core_tb: self-checking bench for the psk frame decoder core
// depends on ptfd_pkg and psk_tag_frame_decoder_core; predicts each result in-bench
module psk_tag_frame_decoder_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ptfd_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;
    localparam int SETTLE_CYCLES = 1000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_item_t in_item;
    logic out_valid;
    logic out_ready;
    out_item_t out_item;
    logic psel;
    logic penable;
    logic pwrite;
    logic [3:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    psk_tag_frame_decoder_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
        .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // clock, 10 ns period
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // predictor state: config copy, four candidate frames, latched result
    logic [9:0] period_q;
    logic [9:0] adjust_q;
    logic [7:0] pattern_q;
    logic [95:0] cand_frames [4];   // bit 0 (oldest) at [95]
    logic [55:0] latched_frame;

    in_item_t pulse_queue [$];
    out_item_t decode_queue [$];
    int errors;
    int frames_seen;
    int results_seen;
    int cycle_count;

    // frame test on one candidate, written straight from the frame layout
    function automatic logic frame_passes(input logic [95:0] f, input logic [7:0] pat);
        logic [3:0] par;
        logic [3:0] sw;
        par = 4'd0;
        for (int n = 0; n < 9; n++)
            par = par ^ f[55 - 4*n -: 4];
        sw = {par[0], par[2:1], par[3]};
        return (f[95:88] == pat) && (f[87:56] == 32'd0) && (sw == f[19:16]);
    endfunction

    // shift count bits into one candidate; 1 when a frame was latched
    function automatic logic shift_candidate(input int r, input logic b, input int dur);
        int cnt;
        if (period_q == 10'd0)
            return 1'b0;
        cnt = (dur + period_q / 2) / period_q;
        if (cnt >= FRAME_BITS)
            return 1'b0;
        for (int k = 0; k < cnt; k++)
        begin
            cand_frames[r] = {cand_frames[r][94:0], b};
            if (frame_passes(cand_frames[r], pattern_q))
            begin
                latched_frame = cand_frames[r][55:0];
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // decode one pulse: try straight phase, then the adjusted phase
    function automatic out_item_t decode_pulse(input in_item_t p);
        out_item_t res;
        logic hit;
        int dur;
        hit = 1'b0;
        dur = p.pulse_duration;
        if (dur > period_q / 2)
        begin
            hit = shift_candidate(0, p.pulse_level, dur);
            if (!hit)
                hit = shift_candidate(1, !p.pulse_level, dur);
        end
        if (!hit && dur > period_q / 4)
        begin
            if (p.pulse_level)
                dur = dur + adjust_q;
            else if (dur > adjust_q)
                dur = dur - adjust_q;
            hit = shift_candidate(2, p.pulse_level, dur);
            if (!hit)
                hit = shift_candidate(3, !p.pulse_level, dur);
        end
        res.frame_found = hit;
        res.card_word = latched_frame[55:24];
        res.trailer_bits = latched_frame[23:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
    endtask

    // ---------------- stimulus building ----------------

    // a well-formed frame for the current pattern, content random
    function automatic logic [95:0] make_frame(input logic [7:0] pat);
        logic [95:0] f;
        logic [3:0] par;
        f = {$urandom, $urandom, $urandom};
        f[95:88] = pat;
        f[87:56] = 32'd0;
        par = 4'd0;
        for (int n = 0; n < 9; n++)
            par = par ^ f[55 - 4*n -: 4];
        f[19:16] = {par[0], par[2:1], par[3]};
        return f;
    endfunction

    // turn a bit string into run-length pulses at the given period
    task automatic queue_frame(input logic [95:0] f, input int per, input logic inv);
        int n;
        int run;
        in_item_t p;
        n = 95;
        while (n >= 0)
        begin
            run = 1;
            while (n - run >= 0 && f[n - run] == f[n])
                run++;
            p.pulse_level = f[n] ^ inv;
            // jitter inside the rounding window
            p.pulse_duration = 20'(run * per + $urandom_range(0, per / 3) - per / 6);
            pulse_queue.push_back(p);
            n = n - run;
        end
    endtask

    task automatic queue_noise(input int count, input int per);
        in_item_t p;
        repeat (count)
        begin
            p.pulse_level = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 5))
                0: p.pulse_duration = 20'($urandom);
                1: p.pulse_duration = 20'($urandom_range(0, per));
                default: p.pulse_duration = 20'($urandom_range(0, 8 * per));
            endcase
            pulse_queue.push_back(p);
        end
    endtask

    // ---------------- driver ----------------
    int send_wait;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_item <= '0;
            send_wait <= 0;
        end
        else if (in_valid && !in_ready)
        begin
            // item still offered, hold it
        end
        else if (send_wait > 0)
        begin
            in_valid <= 1'b0;
            send_wait <= send_wait - 1;
        end
        else if (pulse_queue.size() > 0)
        begin
            // item accepted this edge, or line idle: predict and offer the next
            in_item <= pulse_queue[0];
            decode_queue.push_back(decode_pulse(pulse_queue[0]));
            void'(pulse_queue.pop_front());
            in_valid <= 1'b1;
            send_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
        end
        else
            in_valid <= 1'b0;
    end

    // ---------------- monitor ----------------
    int recv_wait;
    int hold_off;          // long receiver stall, set by the sequencer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_wait <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (decode_queue.size() == 0)
                begin
                    errors++;
                    $display("unexpected item at cycle %0d", cycle_count);
                end
                else
                begin
                    out_item_t want;
                    want = decode_queue.pop_front();
                    if (out_item.frame_found !== want.frame_found)
                        report_mismatch("frame_found", out_item.frame_found, want.frame_found);
                    if (out_item.card_word !== want.card_word)
                        report_mismatch("card_word", out_item.card_word, want.card_word);
                    if (out_item.trailer_bits !== want.trailer_bits)
                        report_mismatch("trailer_bits", out_item.trailer_bits,
                                        want.trailer_bits);
                    if (want.frame_found)
                        frames_seen++;
                end
            end
            if (hold_off > 0)
                out_ready <= 1'b0;
            else if (out_valid && out_ready)
            begin
                recv_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
                out_ready <= 1'b0;
            end
            else if (recv_wait > 0)
            begin
                recv_wait <= recv_wait - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // long stall counter, its own process
    always @(posedge clk)
        if (hold_off > 0)
            hold_off <= hold_off - 1;

    // ---------------- cycle limit ----------------
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout with %0d items outstanding", decode_queue.size());
            $display("FAIL psk_tag_frame_decoder_core");
            $finish;
        end
    end

    // ---------------- register writes ----------------
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_PERIOD: period_q = val[9:0];
            REG_ADJUST: adjust_q = val[9:0];
            REG_PREAMBLE: pattern_q = val[7:0];
            default: ;
        endcase
    endtask

    // wait for the driver to drain and every result to arrive
    task automatic drain();
        while (pulse_queue.size() > 0 || decode_queue.size() > 0 || in_valid)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one phase: some framed traffic at the current period plus noise
    task automatic run_phase(input int frames, input int noise);
        int per;
        per = (period_q == 0) ? 64 : period_q;
        for (int k = 0; k < frames; k++)
        begin
            if ($urandom_range(0, 4) == 0)
                queue_noise($urandom_range(1, 4), per);
            queue_frame(make_frame(pattern_q), per, 1'($urandom_range(0, 1)));
        end
        queue_noise(noise, per);
    endtask

    initial
    begin
        in_item_t p;
        errors = 0;
        frames_seen = 0;
        results_seen = 0;
        cycle_count = 0;
        hold_off = 0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        rst_n = 1'b0;
        period_q = PERIOD_RST;
        adjust_q = ADJUST_RST;
        pattern_q = PREAMBLE_RST;
        for (int r = 0; r < 4; r++)
            cand_frames[r] = '0;
        latched_frame = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: field extremes and rounding edges at reset config
        p = '{1'b0, 20'd0};           pulse_queue.push_back(p);
        p = '{1'b1, 20'hFFFFF};       pulse_queue.push_back(p);
        p = '{1'b1, 20'd63};          pulse_queue.push_back(p);
        p = '{1'b0, 20'd64};          pulse_queue.push_back(p);
        p = '{1'b1, 20'd127};         pulse_queue.push_back(p);
        p = '{1'b0, 20'd128};         pulse_queue.push_back(p);
        p = '{1'b0, 20'd100};         pulse_queue.push_back(p);
        p = '{1'b1, 20'd24352};       pulse_queue.push_back(p);  // just under 96 bits
        p = '{1'b0, 20'd24353};       pulse_queue.push_back(p);  // long pulse
        p = '{1'b1, 20'hAAAAA};       pulse_queue.push_back(p);
        p = '{1'b0, 20'h55555};       pulse_queue.push_back(p);
        queue_frame(make_frame(pattern_q), 255, 1'b0);
        drain();

        // reset config, random frames; long receiver stall while sender fills
        hold_off = 3000;
        run_phase(3, 30);
        drain();

        // small period, big adjust, all-ones preamble
        write_reg(REG_PERIOD, 32'd16);
        write_reg(REG_ADJUST, 32'd1023);
        write_reg(REG_PREAMBLE, 32'hFF);
        run_phase(2, 30);
        drain();

        // largest period, zero adjust, all-zero preamble
        write_reg(REG_PERIOD, 32'h3FF);
        write_reg(REG_ADJUST, 32'd0);
        write_reg(REG_PREAMBLE, 32'h00);
        run_phase(2, 20);
        drain();

        // zero period pushes nothing; out-of-range bits above the fields
        write_reg(REG_PERIOD, 32'hFFFF_FC00);
        queue_noise(15, 100);
        drain();

        // mid settings with random values
        write_reg(REG_PERIOD, $urandom_range(16, 200));
        write_reg(REG_ADJUST, $urandom_range(0, 1023));
        write_reg(REG_PREAMBLE, $urandom_range(0, 255));
        run_phase(2, 30);
        drain();

        write_reg(REG_PERIOD, $urandom_range(17, 90));
        write_reg(REG_ADJUST, $urandom_range(0, 60));
        write_reg(REG_PREAMBLE, $urandom);
        run_phase(2, 20);
        drain();

        $display("covered %0d results, %0d of them decoded frames, over six register settings",
                 results_seen, frames_seen);
        if (errors == 0)
            $display("PASS psk_tag_frame_decoder_core");
        else
            $display("FAIL psk_tag_frame_decoder_core");
        $finish;
    end
endmodule
